// ----- hw/rtl/sdt_pkg.sv -----
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared sizes, codes and types of the sleep deadline table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam int PID_W  = 16;
  localparam int SECS_W = 32;
  localparam int TICK_W = 48;
  localparam int TPS_W  = 16;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(18);

  // input stream: tuser = opcode, tdata = proc_id, sleep_seconds, now_ticks, system_ready
  localparam int IN_BITS   = PID_W + SECS_W + TICK_W + 1;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  // output stream: tdata = status, has_woken, woken_id, expired
  localparam int OUT_BITS   = 1 + 1 + PID_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_SLEEP = 2'd0,
    OP_WAKE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_MUL,
    ST_ADD,
    ST_FIND,
    ST_WAKE,
    ST_WAKE_END,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]  owner;
    logic [TICK_W-1:0] deadline;
  } slot_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sleep_deadline_table_unit.sv -----
// ----------------------------------------------------------------------------
// sleep_deadline_table_unit
// Table of sleeping process ids with wake deadlines: sleep, wake scan, query.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The slot table sits in a synchronous
// memory with one read port, walked one slot per cycle except while a wake
// scan waits on the output side, so that walk sets the cost. An accepted
// sleep request forms the product, then the saturating add, then walks for
// a free slot; a wake scan walks every slot; an expiry query walks until a
// hit or the last slot; a rejected request or unknown opcode needs no walk.
// Results wait in an output register, so the next transaction can be
// taken while the last result is still unread. Slot occupancy is held in
// flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module sleep_deadline_table_unit
  import sdt_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  // configuration: timer ticks per second
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [TPS_W-1:0]      cfg_data,
  // input stream
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // proc_id[15:0], sleep_seconds[47:16], now_ticks[95:48], system_ready[96]
  input  wire  [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  wire  [1:0]            s_tuser,
  // output stream
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // status[0], has_woken[1], woken_id[17:2], expired[18]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(TABLE_SLOTS - 1);

  // input field slices
  logic [PID_W-1:0]  in_pid;
  logic [SECS_W-1:0] in_secs;
  logic [TICK_W-1:0] in_now;
  logic              in_ready;
  opcode_t           in_op;

  assign in_pid   = s_tdata[PID_W-1:0];
  assign in_secs  = s_tdata[PID_W +: SECS_W];
  assign in_now   = s_tdata[PID_W + SECS_W +: TICK_W];
  assign in_ready = s_tdata[PID_W + SECS_W + TICK_W];
  assign in_op    = opcode_t'(s_tuser);

  // registers
  state_t            state;
  state_t            state_next;
  logic [TPS_W-1:0]  tps;
  logic [PID_W-1:0]  pid_r;
  logic [SECS_W-1:0] secs_r;
  logic [TICK_W-1:0] now_r;
  logic [TICK_W-1:0] span;
  logic [TICK_W-1:0] dl;
  logic              resp_status;
  logic              resp_expired;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  logic [CNT_W-1:0]  cnt;
  logic              pend_valid;
  logic [PID_W-1:0]  pend_id;
  logic [TABLE_SLOTS-1:0] occ;

  // slot memory
  slot_entry_t mem [TABLE_SLOTS];
  slot_entry_t rd_data;

  // control decode
  logic              accept;
  logic              out_free;
  logic              is_last;
  logic              due;
  logic              match;
  logic              hit_done;
  logic [TICK_W:0]   dl_sum;

  // actions
  logic              emit;
  logic              e_status;
  logic              e_woken;
  logic [PID_W-1:0]  e_id;
  logic              e_expired;
  logic              e_last;
  logic              mem_we;
  logic              occ_clr;
  logic              pend_load;
  logic              pend_drop;
  logic              idx_adv;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign is_last   = (idx == IDX_LAST);

  assign due   = occ[idx] && (rd_data.deadline <= now_r) && (cnt < CNT_W'(MAX_RESULTS));
  assign match = occ[idx] && (rd_data.owner == pid_r);
  // query finishes here: a hit, or the last slot without one
  assign hit_done = match || is_last;

  assign dl_sum = {1'b0, now_r} + {1'b0, span};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_op)
            OP_SLEEP: begin
              if (in_secs == '0 || !in_ready || in_pid == '0) begin
                state_next = ST_RESP;
              end else begin
                state_next = ST_MUL;
              end
            end
            OP_WAKE:  state_next = ST_WAKE;
            OP_QUERY: state_next = (in_pid == '0) ? ST_RESP : ST_QUERY;
            default:  state_next = ST_RESP;
          endcase
        end
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_FIND;
      ST_FIND: begin
        if (out_free && (!occ[idx] || is_last)) state_next = ST_IDLE;
      end
      ST_WAKE: begin
        if (is_last && !(due && pend_valid && !out_free)) state_next = ST_WAKE_END;
      end
      ST_WAKE_END: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_QUERY: begin
        if (hit_done && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // actions per state
  always_comb begin
    emit      = 1'b0;
    e_status  = 1'b0;
    e_woken   = 1'b0;
    e_id      = '0;
    e_expired = 1'b0;
    e_last    = 1'b1;
    mem_we    = 1'b0;
    occ_clr   = 1'b0;
    pend_load = 1'b0;
    pend_drop = 1'b0;
    idx_adv   = 1'b0;
    case (state)
      ST_RESP: begin
        emit      = out_free;
        e_status  = resp_status;
        e_expired = resp_expired;
      end
      ST_FIND: begin
        if (!occ[idx]) begin
          emit   = out_free;
          mem_we = out_free;
        end else if (is_last) begin
          // table full
          emit     = out_free;
          e_status = 1'b1;
        end else begin
          idx_adv = 1'b1;
        end
      end
      ST_WAKE: begin
        e_woken = 1'b1;
        e_id    = pend_id;
        e_last  = 1'b0;
        if (due) begin
          if (!pend_valid) begin
            pend_load = 1'b1;
            occ_clr   = 1'b1;
            idx_adv   = !is_last;
          end else if (out_free) begin
            // earlier wake goes out, this one is held until the next is known
            emit      = 1'b1;
            pend_load = 1'b1;
            occ_clr   = 1'b1;
            idx_adv   = !is_last;
          end
        end else begin
          idx_adv = !is_last;
        end
      end
      ST_WAKE_END: begin
        emit      = out_free;
        e_woken   = pend_valid;
        e_id      = pend_valid ? pend_id : '0;
        pend_drop = out_free;
      end
      ST_QUERY: begin
        if (hit_done) begin
          emit      = out_free;
          e_expired = match ? (rd_data.deadline <= now_r) : 1'b1;
          occ_clr   = out_free && match && (rd_data.deadline <= now_r);
        end else begin
          idx_adv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == ST_IDLE) begin
      idx_next = '0;
    end else if (idx_adv) begin
      idx_next = idx + 1'b1;
    end else begin
      idx_next = idx;
    end
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= '{owner: pid_r, deadline: dl};
    end
    rd_data <= mem[idx_next];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pid_r        <= in_pid;
      secs_r       <= in_secs;
      now_r        <= in_now;
      resp_status  <= (in_op != OP_QUERY);
      resp_expired <= (in_op == OP_QUERY);
    end
    if (state == ST_MUL) begin
      span <= TICK_W'(secs_r * tps);
    end
    if (state == ST_ADD) begin
      dl <= dl_sum[TICK_W] ? {TICK_W{1'b1}} : dl_sum[TICK_W-1:0];
    end
    if (pend_load) begin
      pend_id <= rd_data.owner;
    end
    if (emit) begin
      m_tdata <= OUT_DATA_W'({e_expired, e_id, e_woken, e_status});
      m_tlast <= e_last;
    end
    idx <= idx_next;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tps        <= TPS_RESET;
      occ        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        tps <= cfg_data;
      end
      if (mem_we) begin
        occ[idx] <= 1'b1;
      end else if (occ_clr) begin
        occ[idx] <= 1'b0;
      end
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_WAKE && due && (!pend_valid || out_free)) begin
        cnt <= cnt + 1'b1;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_drop) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
